// ===== hdl/u8v_pkg.sv =====
package u8v_pkg;

  // Default width of the saturating byte counter.
  localparam int LEN_BITS_DEFAULT = 11;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 10;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALLOW_EMPTY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDENT_MODE  = 2'd2;
  localparam logic [CFG_DATA_W-1:0] MAX_BYTES_RESET = 10'd32;

  // Queue between the classifier and the decoder.
  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // Code point limits.
  localparam int CP_W = 21;
  localparam logic [CP_W-1:0] CP_MIN_2     = 21'h000080;
  localparam logic [CP_W-1:0] CP_MIN_3     = 21'h000800;
  localparam logic [CP_W-1:0] CP_MIN_4     = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;
  localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
  localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;

  // Byte classes found by the front end.
  typedef enum logic [2:0] {
    KIND_ASCII = 3'd0,
    KIND_CONT  = 3'd1,
    KIND_LEAD2 = 3'd2,
    KIND_LEAD3 = 3'd3,
    KIND_LEAD4 = 3'd4,
    KIND_BAD   = 3'd5
  } kind_t;

  // Sequence class held while continuations are pending.
  typedef enum logic [1:0] {
    CLS_NONE = 2'd0,
    CLS_2    = 2'd1,
    CLS_3    = 2'd2,
    CLS_4    = 2'd3
  } cls_t;

  typedef enum logic [1:0] {
    VERDICT_VALID    = 2'd0,
    VERDICT_BAD_LEN  = 2'd1,
    VERDICT_BAD_TEXT = 2'd2
  } verdict_t;

  typedef enum logic [2:0] {
    DETAIL_NONE    = 3'd0,
    DETAIL_LENGTH  = 3'd1,
    DETAIL_UTF8    = 3'd2,
    DETAIL_CONTROL = 3'd3,
    DETAIL_CHARSET = 3'd4
  } detail_t;

  // One classified byte as it travels through the queue.
  typedef struct packed {
    logic [5:0] bits;
    kind_t      kind;
    logic       ctrl;
    logic       cs_bad;
    logic       has_byte;
    logic       is_last;
  } item_t;

  // Smallest code point that a sequence class may encode.
  function automatic logic [CP_W-1:0] cls_min(input cls_t c);
    logic [CP_W-1:0] m;
    m = '0;
    unique case (c)
      CLS_2:   m = CP_MIN_2;
      CLS_3:   m = CP_MIN_3;
      CLS_4:   m = CP_MIN_4;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage

// ===== hdl/u8v_front.sv =====
module u8v_front (
  input  logic              ident_mode,
  input  logic              in_valid,
  input  logic [7:0]        in_data_byte,
  input  logic              in_has_byte,
  input  logic              in_is_last,
  input  logic              q_full,
  output logic              in_stall,
  output logic              push,
  output u8v_pkg::item_t    push_item
);
  import u8v_pkg::*;

  logic ident_ok;

  // Identifier set: a-z, 0-9, dash, underscore, dot.
  assign ident_ok = (in_data_byte >= 8'h61 && in_data_byte <= 8'h7A) ||
                    (in_data_byte >= 8'h30 && in_data_byte <= 8'h39) ||
                    in_data_byte == 8'h2D || in_data_byte == 8'h5F ||
                    in_data_byte == 8'h2E;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // Classify the byte so the decoder only needs its kind and payload bits.
  always_comb begin
    push_item          = '0;
    push_item.bits     = in_data_byte[5:0];
    push_item.has_byte = in_has_byte;
    push_item.is_last  = in_is_last;
    push_item.ctrl     = in_data_byte < 8'h20 || in_data_byte == 8'h7F;
    push_item.cs_bad   = ident_mode && !ident_ok;
    priority if (!in_data_byte[7]) begin
      push_item.kind = KIND_ASCII;
    end else if (in_data_byte[7:6] == 2'b10) begin
      push_item.kind = KIND_CONT;
    end else if (in_data_byte[7:5] == 3'b110) begin
      push_item.kind = KIND_LEAD2;
      push_item.bits = {1'b0, in_data_byte[4:0]};
    end else if (in_data_byte[7:4] == 4'b1110) begin
      push_item.kind = KIND_LEAD3;
      push_item.bits = {2'b00, in_data_byte[3:0]};
    end else if (in_data_byte[7:3] == 5'b11110) begin
      push_item.kind = KIND_LEAD4;
      push_item.bits = {3'b000, in_data_byte[2:0]};
    end else begin
      push_item.kind = KIND_BAD;
    end
  end

endmodule

// ===== hdl/u8v_queue.sv =====
module u8v_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  u8v_pkg::item_t    push_item,
  input  logic              pop,
  output logic              full,
  output logic              not_empty,
  output u8v_pkg::item_t    head
);
  import u8v_pkg::*;

  item_t             mem_r [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]     cnt_r, cnt_nxt;

  assign full      = cnt_r == (Q_AW+1)'(Q_DEPTH);
  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage carries no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== hdl/u8v_back.sv =====
module u8v_back #(
  parameter int LEN_BITS = u8v_pkg::LEN_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [u8v_pkg::CFG_DATA_W-1:0] max_bytes,
  input  logic                          allow_empty,
  input  logic                          q_not_empty,
  input  u8v_pkg::item_t                head,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [1:0]                    out_verdict,
  output logic [2:0]                    out_detail
);
  import u8v_pkg::*;

  localparam int CMP_W = (LEN_BITS > CFG_DATA_W) ? LEN_BITS : CFG_DATA_W;

  logic [LEN_BITS-1:0] cnt_r, cnt_nxt;
  logic [1:0]          pend_r, pend_nxt;
  logic [CP_W-1:0]     acc_r, acc_nxt, acc_step;
  cls_t                cls_r, cls_nxt;
  logic                mal_r, mal_nxt;
  logic                ctrl_r, ctrl_nxt;
  logic                csb_r, csb_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          verdict_r, verdict_nxt;
  logic [2:0]          detail_r, detail_nxt;
  logic                slot_free;
  logic                cp_bad;
  logic                mal_fin;
  logic                len_bad;

  assign slot_free   = !out_valid_r || !out_stall;
  assign pop         = q_not_empty && (!head.is_last || slot_free);
  assign out_valid   = out_valid_r;
  assign out_verdict = verdict_r;
  assign out_detail  = detail_r;

  // Code point so far, extended by this continuation byte.
  assign acc_step = {acc_r[CP_W-7:0], head.bits};
  assign cp_bad   = acc_step < cls_min(cls_r) || acc_step > CP_MAX ||
                    (acc_step >= CP_SURR_LO && acc_step <= CP_SURR_HI);

  // Decode one byte, and on the last item form the verdict and clear.
  always_comb begin
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    acc_nxt       = acc_r;
    cls_nxt       = cls_r;
    mal_nxt       = mal_r;
    ctrl_nxt      = ctrl_r;
    csb_nxt       = csb_r;
    verdict_nxt   = verdict_r;
    detail_nxt    = detail_r;
    out_valid_nxt = out_valid_r && out_stall;
    mal_fin       = 1'b0;
    len_bad       = 1'b0;
    if (pop) begin
      if (head.has_byte) begin
        if (!(&cnt_r)) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        ctrl_nxt = ctrl_r | head.ctrl;
        csb_nxt  = csb_r | head.cs_bad;
        if (pend_r != 2'd0) begin
          if (head.kind != KIND_CONT) begin
            mal_nxt  = 1'b1;
            pend_nxt = 2'd0;
            acc_nxt  = '0;
            cls_nxt  = CLS_NONE;
          end else begin
            pend_nxt = pend_r - 1'b1;
            if (pend_r == 2'd1) begin
              mal_nxt = mal_r | cp_bad;
              acc_nxt = '0;
              cls_nxt = CLS_NONE;
            end else begin
              acc_nxt = acc_step;
            end
          end
        end else begin
          unique case (head.kind)
            KIND_ASCII: ;
            KIND_LEAD2: begin
              acc_nxt  = CP_W'(head.bits);
              pend_nxt = 2'd1;
              cls_nxt  = CLS_2;
            end
            KIND_LEAD3: begin
              acc_nxt  = CP_W'(head.bits);
              pend_nxt = 2'd2;
              cls_nxt  = CLS_3;
            end
            KIND_LEAD4: begin
              acc_nxt  = CP_W'(head.bits);
              pend_nxt = 2'd3;
              cls_nxt  = CLS_4;
            end
            default: mal_nxt = 1'b1;
          endcase
        end
      end
      if (head.is_last) begin
        // A sequence still open at the end of the field is malformed.
        mal_fin = mal_nxt || pend_nxt != 2'd0;
        len_bad = (cnt_nxt == '0 && !allow_empty) ||
                  CMP_W'(cnt_nxt) > CMP_W'(max_bytes);
        priority if (len_bad) begin
          verdict_nxt = VERDICT_BAD_LEN;
          detail_nxt  = DETAIL_LENGTH;
        end else if (mal_fin) begin
          verdict_nxt = VERDICT_BAD_TEXT;
          detail_nxt  = DETAIL_UTF8;
        end else if (ctrl_nxt) begin
          verdict_nxt = VERDICT_BAD_TEXT;
          detail_nxt  = DETAIL_CONTROL;
        end else if (csb_nxt) begin
          verdict_nxt = VERDICT_BAD_TEXT;
          detail_nxt  = DETAIL_CHARSET;
        end else begin
          verdict_nxt = VERDICT_VALID;
          detail_nxt  = DETAIL_NONE;
        end
        out_valid_nxt = 1'b1;
        cnt_nxt       = '0;
        pend_nxt      = 2'd0;
        acc_nxt       = '0;
        cls_nxt       = CLS_NONE;
        mal_nxt       = 1'b0;
        ctrl_nxt      = 1'b0;
        csb_nxt       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 2'd0;
      acc_r       <= '0;
      cls_r       <= CLS_NONE;
      mal_r       <= 1'b0;
      ctrl_r      <= 1'b0;
      csb_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      acc_r       <= acc_nxt;
      cls_r       <= cls_nxt;
      mal_r       <= mal_nxt;
      ctrl_r      <= ctrl_nxt;
      csb_r       <= csb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload carries no reset.
  always_ff @(posedge clk) begin
    verdict_r <= verdict_nxt;
    detail_r  <= detail_nxt;
  end

endmodule

// ===== hdl/utf8_name_field_validator.sv =====
// Streaming UTF-8 text-field checker. A field arrives one byte per transfer on
// the in_ channel, with in_is_last on its final transfer (an empty field is a
// single transfer with in_has_byte low); exactly one verdict/detail transfer
// comes out per field, in field order. The block sustains one byte per clock
// unless the output stalls: a classifier puts each byte in a four-entry queue,
// a decoder drains one entry per cycle, and the last entry passes the queue and
// the output register before out_valid rises. The decoder holds on a last byte
// only while the output register is occupied and stalled, and the queue absorbs
// up to three more bytes behind it before in_stall rises. Write max_bytes,
// allow_empty and identifier_mode through cfg_ only while no field is in flight.
module utf8_name_field_validator #(
  parameter int LENGTH_COUNTER_BITS = u8v_pkg::LEN_BITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [u8v_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [u8v_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [7:0]                     in_data_byte,
  input  logic                           in_has_byte,
  input  logic                           in_is_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_verdict,
  output logic [2:0]                     out_detail
);
  import u8v_pkg::*;

  logic [CFG_DATA_W-1:0] max_bytes_r;
  logic                  allow_empty_r;
  logic                  ident_mode_r;
  logic                  push;
  item_t                 push_item;
  logic                  pop;
  logic                  q_full;
  logic                  q_not_empty;
  item_t                 head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_bytes_r   <= MAX_BYTES_RESET;
      allow_empty_r <= 1'b0;
      ident_mode_r  <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MAX_BYTES:   max_bytes_r   <= cfg_wdata;
        REG_ALLOW_EMPTY: allow_empty_r <= cfg_wdata[0];
        REG_IDENT_MODE:  ident_mode_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  u8v_front u_front (
    .ident_mode   (ident_mode_r),
    .in_valid     (in_valid),
    .in_data_byte (in_data_byte),
    .in_has_byte  (in_has_byte),
    .in_is_last   (in_is_last),
    .q_full       (q_full),
    .in_stall     (in_stall),
    .push         (push),
    .push_item    (push_item)
  );

  u8v_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  u8v_back #(
    .LEN_BITS (LENGTH_COUNTER_BITS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .max_bytes   (max_bytes_r),
    .allow_empty (allow_empty_r),
    .q_not_empty (q_not_empty),
    .head        (head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_verdict (out_verdict),
    .out_detail  (out_detail)
  );

endmodule

// ===== tb/sv/tb_utf8_name_field_validator.sv =====
module tb_utf8_name_field_validator;
  timeunit 1ns;
  timeprecision 1ps;

  import u8v_pkg::*;

  localparam int LEN_BITS = LEN_BITS_DEFAULT;
  localparam logic [LEN_BITS-1:0] LEN_SAT = '1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 16;
  localparam int WATCHDOG_LIMIT = 5000;

  // One transfer on the input channel.
  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       last;
  } field_xfer_t;

  // Verdict expected for one finished field.
  typedef struct packed {
    verdict_t verdict;
    detail_t  detail;
  } field_verdict_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = '0;
  logic       in_has_byte = 1'b0;
  logic       in_is_last = 1'b0;

  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_verdict;
  logic [2:0] out_detail;

  utf8_name_field_validator #(
    .LENGTH_COUNTER_BITS(LEN_BITS)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data_byte(in_data_byte),
    .in_has_byte (in_has_byte),
    .in_is_last  (in_is_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_verdict (out_verdict),
    .out_detail  (out_detail)
  );

  // Transfers waiting to be offered and verdicts waiting to come out.
  field_xfer_t    send_q[$];
  field_verdict_t verdict_q[$];
  field_xfer_t    cur_xfer;
  int             xfers_open = 0;
  int             items_queued = 0;
  int             mismatch_count = 0;
  int             idle_cycles = 0;
  int unsigned    send_idle_pct = 0;
  int unsigned    recv_idle_pct = 0;

  // Shadow copy of the registers.
  logic [CFG_DATA_W-1:0] cfg_max = MAX_BYTES_RESET;
  logic                  cfg_allow_empty = 1'b0;
  logic                  cfg_ident = 1'b0;

  // Decoder state of the field being tracked.
  logic [1:0]          pend_cont = '0;
  logic [CP_W-1:0]     cp_acc = '0;
  cls_t                seq_cls = CLS_NONE;
  logic [LEN_BITS-1:0] len_count = '0;
  logic                bad_utf8 = 1'b0;
  logic                ctrl_hit = 1'b0;
  logic                charset_hit = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic is_ident_char(input logic [7:0] b);
    return (b >= 8'h61 && b <= 8'h7a) || (b >= 8'h30 && b <= 8'h39) ||
           b == 8'h2d || b == 8'h5f || b == 8'h2e;
  endfunction

  // Advance the field tracker by one accepted transfer; a last transfer
  // yields the expected verdict and clears the field.
  task automatic track_transfer(input field_xfer_t x);
    field_verdict_t  res;
    logic [CP_W-1:0] floor_cp;
    if (x.has) begin
      if (len_count != LEN_SAT) len_count = len_count + 1'b1;
      if (x.data < 8'h20 || x.data == 8'h7f) ctrl_hit = 1'b1;
      if (cfg_ident && !is_ident_char(x.data)) charset_hit = 1'b1;
      if (pend_cont != 2'd0) begin
        if (x.data[7:6] != 2'b10) begin
          // A broken sequence is dropped; decoding restarts at the next byte.
          bad_utf8 = 1'b1;
          pend_cont = 2'd0;
          cp_acc = '0;
          seq_cls = CLS_NONE;
        end else begin
          cp_acc = {cp_acc[CP_W-7:0], x.data[5:0]};
          pend_cont = pend_cont - 2'd1;
          if (pend_cont == 2'd0) begin
            case (seq_cls)
              CLS_2:   floor_cp = CP_MIN_2;
              CLS_3:   floor_cp = CP_MIN_3;
              CLS_4:   floor_cp = CP_MIN_4;
              default: floor_cp = '0;
            endcase
            if (cp_acc < floor_cp || cp_acc > CP_MAX ||
                (cp_acc >= CP_SURR_LO && cp_acc <= CP_SURR_HI))
              bad_utf8 = 1'b1;
            cp_acc = '0;
            seq_cls = CLS_NONE;
          end
        end
      end else if (x.data[7]) begin
        casez (x.data)
          8'b110?????: begin
            cp_acc = {16'd0, x.data[4:0]};
            pend_cont = 2'd1;
            seq_cls = CLS_2;
          end
          8'b1110????: begin
            cp_acc = {17'd0, x.data[3:0]};
            pend_cont = 2'd2;
            seq_cls = CLS_3;
          end
          8'b11110???: begin
            cp_acc = {18'd0, x.data[2:0]};
            pend_cont = 2'd3;
            seq_cls = CLS_4;
          end
          default: bad_utf8 = 1'b1;
        endcase
      end
    end
    if (x.last) begin
      if (pend_cont != 2'd0) bad_utf8 = 1'b1;
      if ((len_count == '0 && !cfg_allow_empty) || len_count > cfg_max) begin
        res.verdict = VERDICT_BAD_LEN;
        res.detail  = DETAIL_LENGTH;
      end else if (bad_utf8) begin
        res.verdict = VERDICT_BAD_TEXT;
        res.detail  = DETAIL_UTF8;
      end else if (ctrl_hit) begin
        res.verdict = VERDICT_BAD_TEXT;
        res.detail  = DETAIL_CONTROL;
      end else if (charset_hit) begin
        res.verdict = VERDICT_BAD_TEXT;
        res.detail  = DETAIL_CHARSET;
      end else begin
        res.verdict = VERDICT_VALID;
        res.detail  = DETAIL_NONE;
      end
      verdict_q = {verdict_q, res};
      pend_cont = '0;
      cp_acc = '0;
      seq_cls = CLS_NONE;
      len_count = '0;
      bad_utf8 = 1'b0;
      ctrl_hit = 1'b0;
      charset_hit = 1'b0;
    end
  endtask

  // Driver: offers queued transfers, holding each one while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        track_transfer(cur_xfer);
        xfers_open--;
      end
      if (!in_valid || !in_stall) begin
        if (send_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cur_xfer = send_q.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= cur_xfer.data;
          in_has_byte <= cur_xfer.has;
          in_is_last <= cur_xfer.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each verdict transfer against the oldest expectation.
  always @(posedge clk) begin : monitor
    field_verdict_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (verdict_q.size() == 0) begin
          $error("unexpected verdict transfer: verdict %0d detail %0d",
                 out_verdict, out_detail);
          mismatch_count++;
        end else begin
          want = verdict_q.pop_front();
          if (out_verdict !== want.verdict) begin
            $error("verdict: expected %0d, got %0d", want.verdict, out_verdict);
            mismatch_count++;
          end
          if (out_detail !== want.detail) begin
            $error("detail: expected %0d, got %0d", want.detail, out_detail);
            mismatch_count++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("utf8_name_field_validator regression: fail");
      $finish;
    end
  end

  task automatic queue_item(input logic [7:0] data, input logic has, input logic last);
    field_xfer_t x;
    x.data = data;
    x.has  = has;
    x.last = last;
    send_q = {send_q, x};
    xfers_open++;
    if (has || last) items_queued++;
  endtask

  // Encode a code point in n bytes (overlong if it fits in fewer) and queue
  // the first keep of them.
  task automatic queue_char(input logic [CP_W-1:0] cp, input int n, input int keep,
                            input logic last);
    logic [7:0] bs [4];
    bs[0] = cp[7:0];
    bs[1] = '0;
    bs[2] = '0;
    bs[3] = '0;
    case (n)
      2: begin
        bs[0] = {3'b110, cp[10:6]};
        bs[1] = {2'b10, cp[5:0]};
      end
      3: begin
        bs[0] = {4'b1110, cp[15:12]};
        bs[1] = {2'b10, cp[11:6]};
        bs[2] = {2'b10, cp[5:0]};
      end
      4: begin
        bs[0] = {5'b11110, cp[20:18]};
        bs[1] = {2'b10, cp[17:12]};
        bs[2] = {2'b10, cp[11:6]};
        bs[3] = {2'b10, cp[5:0]};
      end
      default: ;
    endcase
    for (int i = 0; i < keep; i++) queue_item(bs[i], 1'b1, last && i == keep - 1);
  endtask

  function automatic logic [7:0] ident_pick();
    int r;
    r = $urandom_range(0, 38);
    if (r < 26) return 8'h61 + r[7:0];
    if (r < 36) return 8'h30 + r[7:0] - 8'd26;
    if (r == 36) return 8'h2d;
    if (r == 37) return 8'h5f;
    return 8'h2e;
  endfunction

  // Pick a well-formed character; n_force of zero lets the byte count vary.
  task automatic pick_char(input int n_force, output logic [CP_W-1:0] cp, output int n);
    n = n_force;
    if (n == 0) begin
      if ($urandom_range(0, 99) < (cfg_ident ? 85 : 40)) n = 1;
      else n = $urandom_range(2, 4);
    end
    case (n)
      1: begin
        if (cfg_ident && $urandom_range(0, 99) < 85) cp = {13'd0, ident_pick()};
        else cp = CP_W'($urandom_range(32'h20, 32'h7e));
      end
      2: cp = CP_W'($urandom_range(32'h80, 32'h7ff));
      3: begin
        cp = CP_W'($urandom_range(32'h800, 32'hffff));
        if (cp >= CP_SURR_LO && cp <= CP_SURR_HI) cp = cp + 21'h800;
      end
      default: cp = CP_W'($urandom_range(32'h10000, 32'h10ffff));
    endcase
  endtask

  // A run of n plain bytes; n of zero is an empty field.
  task automatic queue_run(input int n);
    if (n == 0) queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    for (int i = 0; i < n; i++) queue_item(ident_pick(), 1'b1, i == n - 1);
  endtask

  // One broken character: overlong, surrogate, too large, a stray byte, or a
  // sequence cut short by the next character.
  task automatic queue_malformed(input logic last);
    logic [CP_W-1:0] cp;
    int n;
    case ($urandom_range(0, 6))
      0: queue_char(CP_W'($urandom_range(0, 32'h7f)), 2, 2, last);
      1: queue_char(CP_W'($urandom_range(0, 32'h7ff)), 3, 3, last);
      2: queue_char(CP_W'($urandom_range(0, 32'hffff)), 4, 4, last);
      3: queue_char(CP_W'($urandom_range(32'hd800, 32'hdfff)), 3, 3, last);
      4: queue_char(CP_W'($urandom_range(32'h110000, 32'h1fffff)), 4, 4, last);
      5: begin
        if ($urandom_range(0, 1) != 0)
          queue_item(8'($urandom_range(8'hf8, 8'hff)), 1'b1, last);
        else
          queue_item(8'($urandom_range(8'h80, 8'hbf)), 1'b1, last);
      end
      default: begin
        pick_char($urandom_range(2, 4), cp, n);
        queue_char(cp, n, $urandom_range(1, n - 1), 1'b0);
        pick_char(1, cp, n);
        queue_char(cp, 1, 1, last);
      end
    endcase
  endtask

  // One random field, mostly well formed, with occasional faults.
  task automatic add_random_field();
    int sel, nch, pos, nb, n;
    logic gap_end, lastc;
    logic [CP_W-1:0] cp;
    sel = $urandom_range(0, 99);
    gap_end = ($urandom_range(0, 9) == 0);
    if (sel >= 96) begin
      queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end else if (sel >= 92) begin
      nb = $urandom_range(1, 8);
      for (int k = 0; k < nb; k++)
        queue_item(8'($urandom_range(0, 255)), 1'b1, !gap_end && k == nb - 1);
      if (gap_end) queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end else if (sel >= 88 && cfg_max <= 40) begin
      // Lengths around the configured maximum.
      nb = int'(cfg_max) + int'($urandom_range(0, 2)) - 1;
      queue_run(nb < 0 ? 0 : nb);
    end else begin
      nch = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 40) : $urandom_range(1, 6);
      pos = $urandom_range(0, nch - 1);
      for (int k = 0; k < nch; k++) begin
        lastc = !gap_end && (k == nch - 1);
        if ($urandom_range(0, 24) == 0)
          queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        if (k == pos && sel >= 60 && sel < 68) begin
          if ($urandom_range(0, 3) == 0) queue_item(8'h7f, 1'b1, lastc);
          else queue_item(8'($urandom_range(0, 8'h1f)), 1'b1, lastc);
        end else if (k == pos && sel >= 68 && sel < 78) begin
          queue_malformed(lastc);
        end else if (k == nch - 1 && sel >= 78 && sel < 88) begin
          // Sequence cut off by the end of the field.
          pick_char($urandom_range(2, 4), cp, n);
          queue_char(cp, n, $urandom_range(1, n - 1), lastc);
        end else begin
          pick_char(0, cp, n);
          queue_char(cp, n, n, lastc);
        end
      end
      if (gap_end) queue_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    end
  endtask

  task automatic add_random_fields(input int count);
    int goal;
    goal = items_queued + count;
    while (items_queued < goal) add_random_field();
  endtask

  // Wait until every queued transfer is taken and every verdict has come.
  task automatic wait_idle();
    while (xfers_open != 0 || verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MAX_BYTES:   cfg_max = val;
      REG_ALLOW_EMPTY: cfg_allow_empty = val[0];
      REG_IDENT_MODE:  cfg_ident = val[0];
      default: ;
    endcase
  endtask

  // Flag register value with random upper bits, which the block drops.
  function automatic logic [CFG_DATA_W-1:0] flag_word(input logic b);
    logic [CFG_DATA_W-1:0] w;
    w = CFG_DATA_W'($urandom());
    w[0] = b;
    return w;
  endfunction

  task automatic set_config(input int max_b, input logic allow_emp, input logic ident);
    write_reg(REG_MAX_BYTES, CFG_DATA_W'(max_b));
    write_reg(REG_ALLOW_EMPTY, flag_word(allow_emp));
    write_reg(REG_IDENT_MODE, flag_word(ident));
  endtask

  initial begin
    send_idle_pct = 26;
    recv_idle_pct = 59;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed fields under the reset configuration.
    queue_item(8'hff, 1'b0, 1'b1);              // empty field, not allowed
    queue_item(8'h41, 1'b1, 1'b1);              // single plain byte
    queue_item(8'h00, 1'b1, 1'b1);              // control bytes
    queue_item(8'h7f, 1'b1, 1'b1);
    queue_char(21'h0000e9, 2, 2, 1'b1);         // two-byte form
    queue_char(21'h000000, 2, 2, 1'b1);         // overlong
    queue_char(21'h00d800, 3, 3, 1'b1);         // surrogate
    queue_char(21'h110000, 4, 4, 1'b1);         // above the code point range
    queue_char(21'h01f600, 4, 4, 1'b1);         // four-byte form
    queue_char(21'h0020ac, 3, 2, 1'b1);         // cut off at the end
    queue_item(8'hff, 1'b1, 1'b1);              // invalid lead byte
    queue_item(8'h00, 1'b0, 1'b0);              // ignored item inside a field
    queue_item(8'h80, 1'b1, 1'b0);              // lone continuation
    queue_item(8'h00, 1'b0, 1'b1);              // field closed without a byte
    wait_idle();

    // Small maximum, empty fields allowed.
    set_config(8, 1'b1, 1'b0);
    queue_run(8);
    queue_run(9);
    queue_run(0);
    add_random_fields(250);
    wait_idle();

    // Zero maximum in identifier mode; a write to an unused index is ignored.
    send_idle_pct = 59;
    recv_idle_pct = 26;
    set_config(0, 1'b1, 1'b1);
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
    queue_run(0);
    queue_run(1);
    add_random_fields(60);
    wait_idle();

    // Largest maximum with a long field.
    set_config(1023, 1'b0, 1'b1);
    queue_run(150);
    queue_run(0);
    add_random_fields(100);
    wait_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(20, 1'b0, 1'b0);
    add_random_fields(300);
    wait_idle();

    set_config(3, 1'b1, 1'b1);
    add_random_fields(190);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("utf8_name_field_validator regression: pass");
    end else begin
      $display("utf8_name_field_validator regression: fail");
    end
    $finish;
  end

endmodule
